// File: design/lifo_stack_with_search_defines.svh
// Assertion macros for the port-level stack checker.
`ifndef LIFO_STACK_WITH_SEARCH_DEFINES_SVH
`define LIFO_STACK_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, muted during reset.
`define LSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lifo_stack_with_search: same-cycle check failed");

// Next-cycle implication, muted during reset.
`define LSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lifo_stack_with_search: next-cycle check failed");

`endif

// File: design/lss_pkg.sv
// Types and constants shared by the LIFO stack with search.
package lss_pkg;

   localparam int DEPTH    = 8;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int TYPE_W   = 3;
   localparam int POS_W    = 3;
   localparam int STATUS_W = 3;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [TYPE_W-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_SEARCH = 3'd3,
      OP_UPDATE = 3'd4
   } lss_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_OVERFLOW  = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_BAD_POS   = 3'd4
   } lss_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_SCAN,
      S_DONE
   } lss_state_type;

   typedef struct packed {
      logic                     we;
      logic [IDX_W-1:0]         waddr;
      logic signed [DATA_W-1:0] wdata;
      logic                     re;
      logic [IDX_W-1:0]         raddr;
   } lss_mem_req_type;

endpackage

// File: design/lss_req_if.sv
// Request channel: valid/ready handshake with the request fields.
interface lss_req_if;
   logic                              valid;
   logic                              ready;
   logic [lss_pkg::TYPE_W-1:0]        req_type;
   logic signed [lss_pkg::DATA_W-1:0] data_value;
   logic [lss_pkg::POS_W-1:0]         position;

   modport source (output valid, output req_type, output data_value, output position,
                   input ready);
   modport sink   (input valid, input req_type, input data_value, input position,
                   output ready);
endinterface

// File: design/lss_rsp_if.sv
// Response channel: valid/ready handshake with the result fields.
interface lss_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [lss_pkg::DATA_W-1:0] read_data;
   logic [lss_pkg::POS_W-1:0]         found_index;
   logic [lss_pkg::STATUS_W-1:0]      status;

   modport source (output valid, output read_data, output found_index, output status,
                   input ready);
   modport sink   (input valid, input read_data, input found_index, input status,
                   output ready);
endinterface

// File: design/lss_store.sv
// Stack word memory: one write port, one read port, registered read data.
module lss_store (
   input  logic                              clock,
   input  lss_pkg::lss_mem_req_type          mem_req,
   output logic signed [lss_pkg::DATA_W-1:0] rd_data
);

   logic signed [lss_pkg::DATA_W-1:0] store_ff [lss_pkg::DEPTH];
   logic signed [lss_pkg::DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_data_ff <= store_ff[mem_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/lifo_stack_with_search.sv
// LIFO stack of signed 32-bit words with push, pop, peek, search and update.
// One transaction is in work at a time; req_chan.ready is high only while the block
// waits for a new one, and a finished result sits in the response register so the next
// transaction can be taken while it waits. Push, update and unknown requests go from
// IDLE straight to DONE, pop and peek pass through READ, and search stays in SCAN
// while the stack memory's single read port reads one entry per cycle from the top
// down. Stored words need no clearing after reset: only entries below the fill count
// are ever read.
module lifo_stack_with_search (
   input  logic       clock,
   input  logic       reset,
   lss_req_if.sink    req_chan,
   lss_rsp_if.source  rsp_chan
);

   lss_pkg::lss_state_type            state_ff, state_in;
   logic [lss_pkg::CNT_W-1:0]         count_ff, count_in;
   logic signed [lss_pkg::DATA_W-1:0] key_ff, key_in;
   logic [lss_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic signed [lss_pkg::DATA_W-1:0] res_data_ff, res_data_in;
   logic [lss_pkg::IDX_W-1:0]         res_idx_ff, res_idx_in;
   lss_pkg::lss_status_type           res_status_ff, res_status_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [lss_pkg::DATA_W-1:0] rsp_data_ff;
   logic [lss_pkg::POS_W-1:0]         rsp_idx_ff;
   lss_pkg::lss_status_type           rsp_status_ff;

   lss_pkg::lss_mem_req_type          mem_req;
   logic signed [lss_pkg::DATA_W-1:0] rd_data;
   lss_pkg::lss_op_type               req_op;
   logic [lss_pkg::IDX_W-1:0]         top_idx;
   logic                              is_empty;
   logic                              is_full;
   logic                              load_out;

   lss_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_op   = lss_pkg::lss_op_type'(req_chan.req_type);
   assign top_idx  = lss_pkg::IDX_W'(count_ff - lss_pkg::CNT_W'(1));
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == lss_pkg::CNT_W'(lss_pkg::DEPTH));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      idx_in        = idx_ff;
      res_data_in   = res_data_ff;
      res_idx_in    = res_idx_ff;
      res_status_in = res_status_ff;
      mem_req       = '0;
      req_chan.ready = 1'b0;
      load_out      = 1'b0;

      case (state_ff)
         lss_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               key_in        = req_chan.data_value;
               res_data_in   = '0;
               res_idx_in    = '0;
               res_status_in = lss_pkg::ST_OK;
               state_in      = lss_pkg::S_DONE;
               case (req_op)
                  lss_pkg::OP_PUSH: begin
                     if (is_full) begin
                        res_status_in = lss_pkg::ST_OVERFLOW;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = count_ff[lss_pkg::IDX_W-1:0];
                        mem_req.wdata = req_chan.data_value;
                        count_in      = count_ff + lss_pkg::CNT_W'(1);
                     end
                  end
                  lss_pkg::OP_POP, lss_pkg::OP_PEEK: begin
                     if (is_empty) begin
                        res_status_in = lss_pkg::ST_EMPTY;
                     end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = top_idx;
                        state_in      = lss_pkg::S_READ;
                        if (req_op == lss_pkg::OP_POP) begin
                           count_in = count_ff - lss_pkg::CNT_W'(1);
                        end
                     end
                  end
                  lss_pkg::OP_SEARCH: begin
                     if (is_empty) begin
                        res_status_in = lss_pkg::ST_EMPTY;
                     end else begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = top_idx;
                        idx_in        = top_idx;
                        state_in      = lss_pkg::S_SCAN;
                     end
                  end
                  lss_pkg::OP_UPDATE: begin
                     if (is_empty) begin
                        res_status_in = lss_pkg::ST_EMPTY;
                     end else if (lss_pkg::CMP_W'(req_chan.position) >=
                                  lss_pkg::CMP_W'(count_ff)) begin
                        res_status_in = lss_pkg::ST_BAD_POS;
                     end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = lss_pkg::IDX_W'(req_chan.position);
                        mem_req.wdata = req_chan.data_value;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         lss_pkg::S_READ: begin
            res_data_in = rd_data;
            state_in    = lss_pkg::S_DONE;
         end
         lss_pkg::S_SCAN: begin
            // rd_data holds entry idx_ff; fetch the next one down in the same cycle
            if (rd_data == key_ff) begin
               res_idx_in = idx_ff;
               state_in   = lss_pkg::S_DONE;
            end else if (idx_ff == '0) begin
               res_status_in = lss_pkg::ST_NOT_FOUND;
               state_in      = lss_pkg::S_DONE;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = idx_ff - lss_pkg::IDX_W'(1);
               idx_in        = idx_ff - lss_pkg::IDX_W'(1);
            end
         end
         lss_pkg::S_DONE: begin
            // hand over once the response register is free or draining
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_out = 1'b1;
               state_in = lss_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lss_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_out | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lss_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      res_data_ff   <= res_data_in;
      res_idx_ff    <= res_idx_in;
      res_status_ff <= res_status_in;
      if (load_out) begin
         rsp_data_ff   <= res_data_ff;
         rsp_idx_ff    <= lss_pkg::POS_W'(res_idx_ff);
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_data   = rsp_data_ff;
   assign rsp_chan.found_index = rsp_idx_ff;
   assign rsp_chan.status      = rsp_status_ff;

endmodule

// File: design/lss_checker.sv
// Port-level checker for the LIFO stack, bound to the top level.
`include "lifo_stack_with_search_defines.svh"

module lss_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [lss_pkg::DATA_W-1:0] rsp_read_data,
   input logic [lss_pkg::POS_W-1:0]         rsp_found_index,
   input logic [lss_pkg::STATUS_W-1:0]      rsp_status
);

   // a stalled response stays up
   `LSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a stalled response keeps its payload
   `LSS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_read_data) && $stable(rsp_found_index) && $stable(rsp_status))

   // one transaction in work at a time
   `LSS_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready)

   // any error status comes with zero data and index
   `LSS_ASSERT_IMPL(a_err_zero, clock, reset, rsp_valid && (rsp_status != lss_pkg::ST_OK), (rsp_read_data == '0) && (rsp_found_index == '0))

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_read_data   (rsp_chan.read_data),
   .rsp_found_index (rsp_chan.found_index),
   .rsp_status      (rsp_chan.status)
);

// File: verif/lss_stack_checker.sv
// Scoreboard for the LIFO stack: predicts each response and compares it with the block.
`timescale 1ns / 1ps

module lss_stack_checker
   import lss_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lss_req_if   req_mon,
   lss_rsp_if   rsp_mon,
   output int   fail_count,
   output int   awaited_count
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_data;
      logic [POS_W-1:0]         found_index;
      logic [STATUS_W-1:0]      status;
   } stack_response_type;

   logic signed [DATA_W-1:0] stack_words [DEPTH];
   int                       stack_fill;
   stack_response_type       awaited_responses [$];
   int                       failures;

   // Apply one request to the shadow stack and return the response it should produce.
   function automatic stack_response_type apply_request(input logic [TYPE_W-1:0] kind,
                                                        input logic signed [DATA_W-1:0] word,
                                                        input logic [POS_W-1:0] pos);
      stack_response_type rsp;
      bit                 hit;
      rsp        = '0;
      rsp.status = ST_OK;
      hit        = 1'b0;
      case (kind)
         OP_PUSH: begin
            if (stack_fill >= DEPTH) begin
               rsp.status = ST_OVERFLOW;
            end else begin
               stack_words[stack_fill] = word;
               stack_fill++;
            end
         end
         OP_POP, OP_PEEK: begin
            if (stack_fill == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               rsp.read_data = stack_words[stack_fill-1];
               if (kind == OP_POP) stack_fill--;
            end
         end
         OP_SEARCH: begin
            if (stack_fill == 0) begin
               rsp.status = ST_EMPTY;
            end else begin
               // scan from the top entry down, stop at the first hit
               for (int i = stack_fill - 1; i >= 0 && !hit; i--) begin
                  if (stack_words[i] == word) begin
                     rsp.found_index = i[POS_W-1:0];
                     hit = 1'b1;
                  end
               end
               if (!hit) rsp.status = ST_NOT_FOUND;
            end
         end
         OP_UPDATE: begin
            if (stack_fill == 0) begin
               rsp.status = ST_EMPTY;
            end else if (int'(pos) >= stack_fill) begin
               rsp.status = ST_BAD_POS;
            end else begin
               stack_words[pos] = word;
            end
         end
         default: begin
         end
      endcase
      return rsp;
   endfunction

   always @(posedge clock) begin
      stack_response_type seen;
      stack_response_type want;
      if (reset) begin
         stack_fill = 0;
         awaited_responses.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            awaited_responses.push_back(apply_request(req_mon.req_type, req_mon.data_value,
                                                      req_mon.position));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.read_data   = rsp_mon.read_data;
            seen.found_index = rsp_mon.found_index;
            seen.status      = rsp_mon.status;
            if (awaited_responses.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: response with none outstanding: data=%h index=%0d status=%0d",
                           $realtime, seen.read_data, seen.found_index, seen.status);
            end else begin
               want = awaited_responses.pop_front();
               if (seen.read_data !== want.read_data || seen.found_index !== want.found_index ||
                   seen.status !== want.status) begin
                  failures++;
                  if (failures <= REPORT_LIMIT)
                     $display("%0t: mismatch: data exp %h got %h, index exp %0d got %0d, %s",
                              $realtime, want.read_data, seen.read_data, want.found_index,
                              seen.found_index,
                              $sformatf("status exp %0d got %0d", want.status, seen.status));
               end
            end
         end
      end
      awaited_count <= awaited_responses.size();
      fail_count    <= failures;
   end

endmodule

// File: verif/tb_top.sv
// Testbench top for the LIFO stack: clock, reset, request and response-side stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
   import lss_pkg::*;

   localparam int RANDOM_ITEMS    = 1000;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int DRAIN_CYCLES    = 24;
   localparam int TIMEOUT_NS      = 5_000_000;

   localparam logic [TYPE_W-1:0] OP_RESERVED_FIRST = 3'd5;
   localparam logic [TYPE_W-1:0] OP_RESERVED_LAST  = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   awaited_count;
   bit   hold_off_armed = 1'b0;

   lss_req_if req_chan ();
   lss_rsp_if rsp_chan ();

   lifo_stack_with_search DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   lss_stack_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .awaited_count (awaited_count)
   );

   always #5 clock = ~clock;

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one transaction and hold it until the block takes it.
   task automatic send_request(input logic [TYPE_W-1:0] kind,
                               input logic signed [DATA_W-1:0] word,
                               input logic [POS_W-1:0] pos);
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.data_value <= word;
      req_chan.position   <= pos;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic issue(input logic [TYPE_W-1:0] kind, input logic signed [DATA_W-1:0] word,
                        input logic [POS_W-1:0] pos, input bit no_gap);
      int gap;
      send_request(kind, word, pos);
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and hold until every response has come back.
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
   endtask

   // Response side: random back-pressure plus one long hold-off on request.
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off_armed) begin
            hold_off_armed = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_chan.ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 120)) @(posedge clock);
            else repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   initial begin
      logic signed [DATA_W-1:0] key_pool [8];
      logic [TYPE_W-1:0]        kind;
      logic signed [DATA_W-1:0] word;
      int                       r;
      int                       push_w;
      int                       pop_w;
      bit                       grow;

      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= OP_PUSH;
      req_chan.data_value <= '0;
      req_chan.position   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty stack and reserved request codes
      issue(OP_POP,    32'sd0, 3'd0, 1'b0);
      issue(OP_PEEK,   32'sd0, 3'd0, 1'b0);
      issue(OP_SEARCH, 32'sd0, 3'd0, 1'b0);
      issue(OP_UPDATE, 32'sd1, 3'd0, 1'b0);
      issue(OP_RESERVED_FIRST, 32'sh7FFFFFFF, 3'd3, 1'b0);
      issue(OP_RESERVED_FIRST + 3'd1, -32'sd1, 3'd7, 1'b1);
      issue(OP_RESERVED_LAST, 32'sh80000000, 3'd0, 1'b1);
      // fill to the top, with a duplicate so search has to pick the upper copy
      issue(OP_PUSH, 32'sh80000000, 3'd0, 1'b1);
      issue(OP_PUSH, 32'sh7FFFFFFF, 3'd7, 1'b0);
      issue(OP_PUSH, 32'sd0,        3'd0, 1'b1);
      issue(OP_PUSH, -32'sd1,       3'd7, 1'b0);
      issue(OP_PUSH, 32'sh7FFFFFFF, 3'd0, 1'b1);
      issue(OP_PUSH, 32'sh12345678, 3'd0, 1'b0);
      issue(OP_PUSH, 32'shA5A5A5A5, 3'd0, 1'b1);
      issue(OP_PUSH, 32'sh5A5A5A5A, 3'd0, 1'b0);
      issue(OP_PUSH, 32'sd1,        3'd0, 1'b1);
      issue(OP_SEARCH, 32'sh7FFFFFFF, 3'd0, 1'b0);
      issue(OP_SEARCH, 32'sh80000000, 3'd0, 1'b1);
      issue(OP_SEARCH, 32'sd42,       3'd0, 1'b0);
      issue(OP_UPDATE, -32'sd1,       3'd7, 1'b1);
      issue(OP_PEEK,   32'sd0,        3'd0, 1'b0);
      issue(OP_POP,    32'sd0,        3'd0, 1'b1);
      issue(OP_UPDATE, 32'sd9,        3'd7, 1'b0);
      issue(OP_POP,    32'sd0,        3'd0, 1'b0);
      issue(OP_PEEK,   32'sd0,        3'd0, 1'b1);
      wait_drained();

      key_pool[0] = 32'sd0;
      key_pool[1] = -32'sd1;
      key_pool[2] = 32'sh80000000;
      key_pool[3] = 32'sh7FFFFFFF;
      key_pool[4] = 32'sd1;
      for (int k = 5; k < 8; k++) key_pool[k] = $urandom;

      grow = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // alternate push-heavy and pop-heavy stretches to swing between empty and full
         if (n % 64 == 0) grow = ~grow;
         if (n == 300) hold_off_armed = 1'b1;
         if (n == 600) wait_drained();
         push_w = grow ? 45 : 12;
         pop_w  = grow ? 10 : 38;
         r = $urandom_range(0, 99);
         if (r < push_w) kind = OP_PUSH;
         else if (r < push_w + pop_w) kind = OP_POP;
         else if (r < push_w + pop_w + 12) kind = OP_PEEK;
         else if (r < 85) kind = OP_SEARCH;
         else if (r < 97) kind = OP_UPDATE;
         else kind = TYPE_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
         word = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 7)] : $urandom;
         issue(kind, word, POS_W'($urandom_range(0, 7)), (n % 100) < 25);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Verification failed");
      $finish;
   end

endmodule
